FILE: src/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types, constants and helpers for the binary search step counter.
// ----------------------------------------------------------------------------
package bss_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16384;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // field widths fixed by the item format
   localparam int IDX_W  = 14;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;

   // item command codes
   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   // search sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP_MID,
      ST_CMP_LO,
      ST_CMP_HI
   } state_type;

   // input beat
   typedef struct packed {
      cmd_type            cmd;
      logic [IDX_W-1:0]   entry_index;
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]   from_index;
      logic [IDX_W-1:0]   to_index;
   } req_type;

   // result beat
   typedef struct packed {
      logic             found;
      logic [CNT_W-1:0] probe_count;
   } rsp_type;

   // table index to memory address
   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
      return ADDR_W'(idx);
   endfunction

   // index lies inside the table
   function automatic logic in_table(input logic [IDX_W-1:0] idx);
      return (32'(idx) < TABLE_DEPTH);
   endfunction

endpackage

FILE: src/bss_table.sv
// ----------------------------------------------------------------------------
// bss_table
// Single-port table memory: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module bss_table (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [bss_pkg::ADDR_W-1:0]        addr,
   input  logic signed [bss_pkg::DATA_W-1:0] wr_data,
   output logic signed [bss_pkg::DATA_W-1:0] rd_data
);

   logic signed [bss_pkg::DATA_W-1:0] mem_ff [bss_pkg::TABLE_DEPTH];
   logic signed [bss_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bss_search.sv
// ----------------------------------------------------------------------------
// bss_search
// Search sequencer: walks the range with one shared key comparator, one
// table read per step, and counts midpoint probes.
// ----------------------------------------------------------------------------
module bss_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic signed [bss_pkg::DATA_W-1:0] key,
   input  logic [bss_pkg::IDX_W-1:0]         from_index,
   input  logic [bss_pkg::IDX_W-1:0]         to_index,
   input  logic signed [bss_pkg::DATA_W-1:0] rd_data,
   output logic [bss_pkg::ADDR_W-1:0]        rd_addr,
   output logic                              busy,
   output logic                              rsp_strobe,
   output bss_pkg::rsp_type                  rsp_data
);

   bss_pkg::state_type                state_ff, state_in;
   logic [bss_pkg::IDX_W-1:0]         lo_ff, lo_in;
   logic [bss_pkg::IDX_W-1:0]         hi_ff, hi_in;
   logic signed [bss_pkg::DATA_W-1:0] key_ff, key_in;
   logic [bss_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic                              strobe_ff, strobe_in;
   bss_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [bss_pkg::IDX_W:0]           sum;
   logic [bss_pkg::IDX_W-1:0]         mid;
   logic [bss_pkg::IDX_W:0]           span;
   logic                              span_gt1;
   logic                              key_eq;
   logic                              key_gt;

   // midpoint and range distance
   assign sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = sum[bss_pkg::IDX_W:1];
   assign span     = {1'b0, hi_ff} - {1'b0, lo_ff};
   assign span_gt1 = !span[bss_pkg::IDX_W] && (span[bss_pkg::IDX_W-1:1] != '0);

   // shared key comparator
   assign key_eq = (key_ff == rd_data);
   assign key_gt = (key_ff > rd_data);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bss_pkg::ST_IDLE: begin
            if (go) state_in = bss_pkg::ST_PROBE;
         end
         bss_pkg::ST_PROBE: begin
            state_in = bss_pkg::ST_CMP_MID;
         end
         bss_pkg::ST_CMP_MID: begin
            if (key_eq)        state_in = bss_pkg::ST_IDLE;
            else if (span_gt1) state_in = bss_pkg::ST_PROBE;
            else               state_in = bss_pkg::ST_CMP_LO;
         end
         bss_pkg::ST_CMP_LO: begin
            if (key_eq) state_in = bss_pkg::ST_IDLE;
            else        state_in = bss_pkg::ST_CMP_HI;
         end
         bss_pkg::ST_CMP_HI: begin
            state_in = bss_pkg::ST_IDLE;
         end
         default: begin
            state_in = bss_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rd_addr   = bss_pkg::to_addr(mid);
      case (state_ff)
         bss_pkg::ST_IDLE: begin
            if (go) begin
               lo_in  = from_index;
               hi_in  = to_index;
               key_in = key;
               cnt_in = '0;
            end
         end
         bss_pkg::ST_PROBE: begin
            rd_addr = bss_pkg::to_addr(mid);
         end
         bss_pkg::ST_CMP_MID: begin
            // endpoint lo is read next if the range is down to two entries or fewer, or reversed
            rd_addr = bss_pkg::to_addr(lo_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (key_eq) begin
               strobe_in         = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.probe_count = cnt_ff + 1'b1;
            end else if (span_gt1) begin
               if (key_gt) lo_in = mid;
               else        hi_in = mid;
            end
         end
         bss_pkg::ST_CMP_LO: begin
            rd_addr = bss_pkg::to_addr(hi_ff);
            if (key_eq) begin
               strobe_in         = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.probe_count = cnt_ff;
            end
         end
         bss_pkg::ST_CMP_HI: begin
            rd_addr            = bss_pkg::to_addr(hi_ff);
            strobe_in          = 1'b1;
            rsp_in.found       = key_eq;
            rsp_in.probe_count = cnt_ff;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bss_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != bss_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // result strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for more than one cycle");

   // every result reports at least one probe
   a_probe_nonzero: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (rsp_ff.probe_count != '0))
      else $error("result with zero probes");

   // a midpoint compare always follows a probe read
   a_cmp_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bss_pkg::ST_CMP_MID) |-> ($past(state_ff) == bss_pkg::ST_PROBE))
      else $error("midpoint compare without probe read");

   // a result only comes out of a compare step
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == bss_pkg::ST_CMP_MID ||
                     $past(state_ff) == bss_pkg::ST_CMP_LO ||
                     $past(state_ff) == bss_pkg::ST_CMP_HI))
      else $error("result strobe outside a compare step");

endmodule

FILE: src/binary_search_step_count.sv
// A write beat gives no result. A search beat keeps busy high through a table
// read (ST_PROBE) and a compare (ST_CMP_MID) per midpoint probe, plus a compare
// state per endpoint compared (ST_CMP_LO, ST_CMP_HI), serialised by the single
// table port and the shared comparator. The result strobe comes in the same cycle
// as busy falls; a new beat may start then. Up to 15 probes with 14-bit indices.
// Synchronous reset clears the sequencer only; table contents are undefined.
// ----------------------------------------------------------------------------
// binary_search_step_count
// Sorted table with write and search commands; a search reports whether the
// key was found and how many midpoint probes it took.
// ----------------------------------------------------------------------------
module binary_search_step_count (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bss_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bss_pkg::rsp_type rsp_data
);

   logic                              accept;
   logic                              search_go;
   logic                              wr_en;
   logic [bss_pkg::ADDR_W-1:0]        search_addr;
   logic [bss_pkg::ADDR_W-1:0]        table_addr;
   logic signed [bss_pkg::DATA_W-1:0] rd_data;

   // beat decode
   assign accept    = start && !busy;
   assign search_go = accept && (req_data.cmd == bss_pkg::CMD_SEARCH);
   assign wr_en     = accept && (req_data.cmd == bss_pkg::CMD_WRITE) &&
                      bss_pkg::in_table(req_data.entry_index);

   // table port goes to the sequencer while a search runs
   assign table_addr = busy ? search_addr : bss_pkg::to_addr(req_data.entry_index);

   bss_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (table_addr),
      .wr_data (req_data.value),
      .rd_data (rd_data)
   );

   bss_search u_search (
      .clock      (clock),
      .reset      (reset),
      .go         (search_go),
      .key        (req_data.value),
      .from_index (req_data.from_index),
      .to_index   (req_data.to_index),
      .rd_data    (rd_data),
      .rd_addr    (search_addr),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/search_result_checker.sv
// ----------------------------------------------------------------------------
// search_result_checker
// Watches the command and result channels of the binary search step counter,
// keeps a mirror of the table, predicts found and probe count for each
// accepted search and compares every result beat against the oldest one.
// ----------------------------------------------------------------------------
module search_result_checker
   import bss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic signed [DATA_W-1:0] entry_mirror [TABLE_DEPTH];
   rsp_type                  expected_results [$];
   int                       error_total = 0;

   // midpoint probe walk over the mirrored table
   function automatic rsp_type predict_search(input req_type beat);
      int                       lo;
      int                       hi;
      int                       mid;
      int                       span;
      int                       probes;
      logic                     hit;
      logic                     done;
      logic signed [DATA_W-1:0] probe;
      rsp_type                  res;
      lo     = int'(beat.from_index);
      hi     = int'(beat.to_index);
      probes = 0;
      hit    = 1'b0;
      done   = 1'b0;
      while (!done) begin
         mid    = (lo + hi) / 2;
         span   = hi - lo;
         probe  = entry_mirror[mid];
         probes = probes + 1;
         if (beat.value == probe) begin
            hit  = 1'b1;
            done = 1'b1;
         end else if (span > 1) begin
            // keep the midpoint inside the narrowed range
            if (beat.value > probe) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end else begin
            // short or reversed range: compare both endpoints
            hit  = (beat.value == entry_mirror[lo]) || (beat.value == entry_mirror[hi]);
            done = 1'b1;
         end
      end
      res.found       = hit;
      res.probe_count = CNT_W'(probes);
      return res;
   endfunction

   // result check first, then the accepted command beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               if (error_total < REPORT_LIMIT) begin
                  $display("[%0t] unexpected result beat: found=%0b probe_count=%0d",
                           $realtime, rsp_data.found, rsp_data.probe_count);
               end
               error_total = error_total + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.found !== want.found ||
                   rsp_data.probe_count !== want.probe_count) begin
                  if (error_total < REPORT_LIMIT) begin
                     $display("[%0t] expected found=%0b probes=%0d, actual found=%0b probes=%0d",
                              $realtime, want.found, want.probe_count,
                              rsp_data.found, rsp_data.probe_count);
                  end
                  error_total = error_total + 1;
               end
            end
         end
         if (start && !busy) begin
            if (req_data.cmd == CMD_WRITE) begin
               entry_mirror[req_data.entry_index] = req_data.value;
            end else begin
               expected_results.push_back(predict_search(req_data));
            end
         end
      end
      fail_count <= error_total;
      pending    <= expected_results.size();
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the binary search step counter: a short directed sequence on
// a small table, a sorted fill of the top region of the table, then random
// writes and searches in that region with random idle gaps. The checker
// beside the block judges every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import bss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  WATCHDOG_LIMIT = 2000;
   localparam int  DRAIN_CYCLES   = 40;
   localparam int  RANDOM_BEATS   = 1270;
   localparam int  FILL_DEPTH     = 512;
   localparam int  FILL_STEP      = 12582911;
   localparam int  MAX_INDEX      = TABLE_DEPTH - 1;
   localparam int  REGION_LO      = TABLE_DEPTH - FILL_DEPTH;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_data   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles = 0;
   logic    quiet_run   = 1'b0;

   // stimulus-side copy of the table, used to pick keys and ordered values
   logic signed [DATA_W-1:0] table_image [TABLE_DEPTH];

   binary_search_step_count dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   search_result_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // idle gap before a beat, with occasional stretches of back-to-back beats
   function automatic int draw_gap();
      if ($urandom_range(0, 99) < 4) begin
         quiet_run = !quiet_run;
      end
      return quiet_run ? 0 : $urandom_range(0, 9);
   endfunction

   // present one command beat after a gap and hold it until accepted
   task automatic send_beat(input req_type beat, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] val,
                              input int gap);
      req_type beat;
      beat.cmd         = CMD_WRITE;
      beat.entry_index = IDX_W'(idx);
      beat.value       = val;
      beat.from_index  = IDX_W'($urandom);
      beat.to_index    = IDX_W'($urandom);
      table_image[idx] = val;
      send_beat(beat, gap);
   endtask

   task automatic search_range(input int from_idx, input int to_idx,
                               input logic signed [DATA_W-1:0] key, input int gap);
      req_type beat;
      beat.cmd         = CMD_SEARCH;
      beat.entry_index = IDX_W'($urandom);
      beat.value       = key;
      beat.from_index  = IDX_W'(from_idx);
      beat.to_index    = IDX_W'(to_idx);
      send_beat(beat, gap);
   endtask

   // random write: mostly keeps the region ordered, sometimes breaks it
   task automatic random_write();
      int              idx;
      longint          lower;
      longint          upper;
      longint unsigned roll;
      logic signed [DATA_W-1:0] val;
      idx = $urandom_range(REGION_LO, MAX_INDEX);
      if ($urandom_range(0, 99) < 85) begin
         lower = (idx > REGION_LO) ? longint'(table_image[idx-1]) : longint'(WORD_MIN);
         upper = (idx < MAX_INDEX) ? longint'(table_image[idx+1]) : longint'(WORD_MAX);
         if (upper < lower) begin
            val = DATA_W'(lower);
         end else begin
            roll = {$urandom, $urandom};
            val  = DATA_W'(lower + longint'(roll % longint'(upper - lower + 1)));
         end
      end else begin
         val = $urandom;
      end
      write_entry(idx, val, draw_gap());
   endtask

   // random search: range shape and key kind both drawn
   task automatic random_search();
      int from_idx;
      int to_idx;
      int lo;
      int hi;
      int pick;
      int shape;
      int kind;
      logic signed [DATA_W-1:0] key;
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         from_idx = $urandom_range(REGION_LO, MAX_INDEX);
         to_idx   = $urandom_range(REGION_LO, MAX_INDEX);
      end else if (shape < 50) begin
         from_idx = $urandom_range(REGION_LO, MAX_INDEX);
         to_idx   = $urandom_range(from_idx, MAX_INDEX);
      end else if (shape < 80) begin
         from_idx = $urandom_range(REGION_LO, MAX_INDEX);
         to_idx   = from_idx + $urandom_range(0, 7);
         if (to_idx > MAX_INDEX) to_idx = MAX_INDEX;
      end else begin
         from_idx = ($urandom_range(0, 1) == 0) ? REGION_LO :
                    $urandom_range(REGION_LO, MAX_INDEX);
         to_idx   = MAX_INDEX;
      end
      lo   = (from_idx < to_idx) ? from_idx : to_idx;
      hi   = (from_idx < to_idx) ? to_idx : from_idx;
      pick = lo + $urandom_range(0, hi - lo);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         key = table_image[pick];
      end else if (kind < 70) begin
         key = ($urandom_range(0, 1) == 0) ? table_image[pick] + 1 : table_image[pick] - 1;
      end else if (kind < 85) begin
         key = $urandom;
      end else begin
         case ($urandom_range(0, 2))
            0: key = WORD_MIN;
            1: key = WORD_MAX;
            default: key = '0;
         endcase
      end
      search_range(from_idx, to_idx, key, draw_gap());
   endtask

   initial begin
      longint fill_value;
      logic signed [DATA_W-1:0] seed_values [8];
      seed_values = '{WORD_MIN, -32'sd100, -32'sd1, 32'sd0, 32'sd1, 32'sd100,
                      32'sd1000, WORD_MAX};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small ordered table in entries 0 to 7
      for (int i = 0; i < 8; i++) begin
         write_entry(i, seed_values[i], draw_gap());
      end
      search_range(0, 7, WORD_MIN, draw_gap());
      search_range(0, 7, WORD_MAX, draw_gap());
      search_range(0, 7, 32'sd0, draw_gap());
      search_range(0, 7, 32'sd50, draw_gap());
      search_range(0, 7, WORD_MAX - 1, draw_gap());
      // single entry and adjacent pair
      search_range(3, 3, 32'sd0, draw_gap());
      search_range(3, 4, 32'sd1, draw_gap());
      search_range(3, 4, 32'sd7, draw_gap());
      // reversed ranges with an endpoint hit and a miss, then a forward miss
      search_range(5, 2, -32'sd1, draw_gap());
      search_range(7, 0, 32'sd5, draw_gap());
      search_range(2, 6, 32'sd999, draw_gap());

      // fill the top region in ascending order, extremes at both ends
      fill_value = longint'(WORD_MIN);
      for (int i = REGION_LO; i < TABLE_DEPTH; i++) begin
         if (i == MAX_INDEX) fill_value = longint'(WORD_MAX);
         write_entry(i, DATA_W'(fill_value), 0);
         fill_value = fill_value + $urandom_range(0, FILL_STEP);
         if (fill_value > longint'(WORD_MAX)) fill_value = longint'(WORD_MAX);
      end

      // random mix of writes and searches
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(0, 99) < 25) begin
            random_write();
         end else begin
            random_search();
         end
      end
      start <= 1'b0;

      // drain outstanding results, then a short quiet tail
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/bss_pkg.sv
src/bss_table.sv
src/bss_search.sv
src/binary_search_step_count.sv
tb/search_result_checker.sv
tb/tb_top.sv
